FILE: design/pee_pkg.sv
`default_nettype none

package pee_pkg;

    // Characters of the postfix text
    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NEG   = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Expression status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_OPERAND  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam int unsigned DATA_W = 32;
    localparam logic [31:0] NUM_MAX = 32'h7FFF_FFFF;
    localparam logic [3:0]  RADIX   = 4'd10;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic              start;
        t_alu_op           op;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } t_alu_rsp;

endpackage

`default_nettype wire

FILE: design/postfix_expression_evaluator.sv
`default_nettype none

// Channel   Handshake                   Payload
// input     i_valid / o_stall           i_char_code[7:0]
// output    o_valid / i_stall           o_value[31:0] signed, o_status[1:0]
//
// A digit is folded into the accumulator without leaving idle; other characters go through the stack RAM.
// '*' and '/' go through 32 one-bit steps of the shared shift/add unit,
// plus sign fix and stack read/write.
// Character 0 waits in place while the output register holds a result that is stalled.
// Reset is synchronous, active low; it empties the stack and clears the status.
// o_stall is high while a character is being worked; a held result does not block input.
module postfix_expression_evaluator
    import pee_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_char_code,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_value,
    output logic [1:0]              o_status
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_NUM,
        S_DISPATCH,
        S_POP_RHS,
        S_POP_LHS,
        S_EXEC,
        S_WAIT,
        S_PUSH_RES,
        S_NEGATE,
        S_END_READ,
        S_FINISH
    } t_state;

    t_state             r_state, n_state;
    logic [7:0]         r_ch, n_ch;
    logic [CW-1:0]      r_count, n_count;
    logic [31:0]        r_acc, n_acc;
    logic               r_in_number, n_in_number;
    logic [1:0]         r_err, n_err;
    logic [31:0]        r_lhs, n_lhs;
    logic [31:0]        r_rhs, n_rhs;
    logic [31:0]        r_res, n_res;
    logic               r_o_valid, n_o_valid;
    logic [31:0]        r_o_value, n_o_value;
    logic [1:0]         r_o_status, n_o_status;

    logic [31:0]        r_stack [STACK_DEPTH];
    logic [31:0]        r_rd_data;
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [31:0]        wr_data;

    logic [CW-1:0]      count_dec;
    logic [AW-1:0]      top_addr;
    logic               stack_full;
    logic               stack_empty;
    logic               is_digit;
    logic [7:0]         digit_diff;
    logic [35:0]        acc_ext, acc_mul;
    logic [31:0]        acc_sat;

    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;

    assign count_dec   = r_count - CW'(1);
    assign top_addr    = count_dec[AW-1:0];
    assign stack_full  = (r_count == CW'(STACK_DEPTH));
    assign stack_empty = (r_count == '0);

    // Decimal accumulate: acc * 10 + digit, saturating
    assign is_digit   = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign digit_diff = i_char_code - CH_ZERO;
    assign acc_ext    = {4'b0, r_acc};
    assign acc_mul    = acc_ext * 36'(RADIX) + 36'(digit_diff[3:0]);
    assign acc_sat    = (acc_mul > 36'(NUM_MAX)) ? NUM_MAX : acc_mul[31:0];

    pee_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_stack[rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_count     = r_count;
        n_acc       = r_acc;
        n_in_number = r_in_number;
        n_err       = r_err;
        n_lhs       = r_lhs;
        n_rhs       = r_rhs;
        n_res       = r_res;
        n_o_valid   = r_o_valid && i_stall;
        n_o_value   = r_o_value;
        n_o_status  = r_o_status;
        wr_en       = 1'b0;
        wr_addr     = r_count[AW-1:0];
        wr_data     = r_res;
        rd_en       = 1'b0;
        rd_addr     = top_addr;
        alu_req     = '{start: 1'b0, op: ALU_MUL, lhs: r_lhs, rhs: r_rhs};
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ch = i_char_code;
                    if (is_digit) begin
                        n_acc       = r_in_number ? acc_sat : 32'(digit_diff[3:0]);
                        n_in_number = 1'b1;
                    end else if (r_in_number) begin
                        n_state = S_PUSH_NUM;
                    end else begin
                        n_state = S_DISPATCH;
                    end
                end
            end
            S_PUSH_NUM: begin
                if (!stack_full) begin
                    wr_en   = 1'b1;
                    wr_data = r_acc;
                    n_count = r_count + CW'(1);
                end else begin
                    n_err = ST_OVERFLOW;
                end
                n_in_number = 1'b0;
                n_acc       = '0;
                n_state     = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (r_ch)
                    CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
                        if (stack_empty) begin
                            n_err   = ST_OPERAND;
                            n_state = S_IDLE;
                        end else begin
                            rd_en   = 1'b1;
                            n_count = count_dec;
                            n_state = S_POP_RHS;
                        end
                    end
                    CH_NEG: begin
                        if (stack_empty) begin
                            n_err   = ST_OPERAND;
                            n_state = S_IDLE;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_NEGATE;
                        end
                    end
                    CH_END: begin
                        if (stack_empty) begin
                            n_res   = '0;
                            n_state = S_FINISH;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_END_READ;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_POP_RHS: begin
                n_rhs = r_rd_data;
                if (stack_empty) begin
                    // lone operand is dropped
                    n_err   = ST_OPERAND;
                    n_state = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    n_count = count_dec;
                    n_state = S_POP_LHS;
                end
            end
            S_POP_LHS: begin
                n_lhs   = r_rd_data;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_ch)
                    CH_PLUS: begin
                        n_res   = r_lhs + r_rhs;
                        n_state = S_PUSH_RES;
                    end
                    CH_MINUS: begin
                        n_res   = r_lhs - r_rhs;
                        n_state = S_PUSH_RES;
                    end
                    CH_STAR: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = ALU_MUL;
                        n_state       = S_WAIT;
                    end
                    default: begin
                        if (r_rhs == '0) begin
                            n_res   = '0;
                            n_err   = ST_DIVZERO;
                            n_state = S_PUSH_RES;
                        end else begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_DIV;
                            n_state       = S_WAIT;
                        end
                    end
                endcase
            end
            S_WAIT: begin
                if (alu_rsp.done) begin
                    n_res   = alu_rsp.result;
                    n_state = S_PUSH_RES;
                end
            end
            S_PUSH_RES: begin
                if (!stack_full) begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                end else begin
                    n_err = ST_OVERFLOW;
                end
                n_state = S_IDLE;
            end
            S_NEGATE: begin
                wr_en   = 1'b1;
                wr_addr = top_addr;
                wr_data = 32'd0 - r_rd_data;
                n_state = S_IDLE;
            end
            S_END_READ: begin
                n_res   = r_rd_data;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!r_o_valid || !i_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_value  = r_res;
                    n_o_status = r_err;
                    n_count    = '0;
                    n_err      = ST_OK;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_acc       <= '0;
            r_in_number <= 1'b0;
            r_err       <= ST_OK;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_acc       <= n_acc;
            r_in_number <= n_in_number;
            r_err       <= n_err;
            r_o_valid   <= n_o_valid;
        end
        r_ch       <= n_ch;
        r_lhs      <= n_lhs;
        r_rhs      <= n_rhs;
        r_res      <= n_res;
        r_o_value  <= n_o_value;
        r_o_status <= n_o_status;
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_o_valid;
    assign o_value  = $signed(r_o_value);
    assign o_status = r_o_status;

endmodule

`default_nettype wire

FILE: design/pee_alu.sv
`default_nettype none

// Shift-and-add multiplier and restoring divider sharing one adder.
// 32 steps of one bit each, then one step that fixes the quotient sign of a divide.
module pee_alu
    import pee_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    localparam int unsigned ADD_W = DATA_W + 2;

    typedef enum logic [1:0] {
        A_IDLE,
        A_RUN,
        A_FIX
    } t_alu_state;

    t_alu_state          r_state, n_state;
    t_alu_op             r_op, n_op;
    logic [DATA_W-1:0]   r_x, n_x;
    logic [DATA_W-1:0]   r_y, n_y;
    logic [DATA_W-1:0]   r_acc, n_acc;
    logic                r_neg, n_neg;
    logic [4:0]          r_step, n_step;
    logic                r_done, n_done;
    logic [DATA_W-1:0]   r_result, n_result;

    logic [ADD_W-1:0]    add_a, add_b, add_sum;
    logic                add_sub;

    // The one adder / subtractor
    assign add_sum = add_a + (add_b ^ {ADD_W{add_sub}}) + ADD_W'(add_sub);

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (r_state)
            A_RUN: begin
                if (r_op == ALU_MUL) begin
                    add_a = ADD_W'(r_acc);
                    add_b = r_y[0] ? ADD_W'(r_x) : '0;
                end else begin
                    add_a   = {1'b0, r_acc, r_x[DATA_W-1]};
                    add_b   = ADD_W'(r_y);
                    add_sub = 1'b1;
                end
            end
            A_FIX: begin
                if (r_op == ALU_MUL) begin
                    add_b = ADD_W'(r_acc);
                end else begin
                    add_b   = ADD_W'(r_x);
                    add_sub = r_neg;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_x      = r_x;
        n_y      = r_y;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_step   = r_step;
        n_done   = 1'b0;
        n_result = r_result;
        case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_op   = i_req.op;
                    n_acc  = '0;
                    n_step = 5'd31;
                    n_neg  = i_req.lhs[DATA_W-1] ^ i_req.rhs[DATA_W-1];
                    if (i_req.op == ALU_MUL) begin
                        n_x = i_req.lhs;
                        n_y = i_req.rhs;
                    end else begin
                        // operate on magnitudes, fix the sign at the end
                        n_x = i_req.lhs[DATA_W-1] ? (DATA_W'(0) - i_req.lhs) : i_req.lhs;
                        n_y = i_req.rhs[DATA_W-1] ? (DATA_W'(0) - i_req.rhs) : i_req.rhs;
                    end
                    n_state = A_RUN;
                end
            end
            A_RUN: begin
                if (r_op == ALU_MUL) begin
                    n_acc = add_sum[DATA_W-1:0];
                    n_x   = {r_x[DATA_W-2:0], 1'b0};
                    n_y   = {1'b0, r_y[DATA_W-1:1]};
                end else begin
                    // keep the partial remainder only if the trial subtract did not go negative
                    n_acc = add_sum[ADD_W-1] ? add_a[DATA_W-1:0] : add_sum[DATA_W-1:0];
                    n_x   = {r_x[DATA_W-2:0], ~add_sum[ADD_W-1]};
                end
                n_step = r_step - 5'd1;
                if (r_step == 5'd0) begin
                    n_state = A_FIX;
                end
            end
            A_FIX: begin
                n_result = add_sum[DATA_W-1:0];
                n_done   = 1'b1;
                n_state  = A_IDLE;
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_op     <= n_op;
        r_x      <= n_x;
        r_y      <= n_y;
        r_acc    <= n_acc;
        r_neg    <= n_neg;
        r_step   <= n_step;
        r_result <= n_result;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule

`default_nettype wire

FILE: design/pee_checker.sv
`default_nettype none

module pee_checker
    import pee_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [7:0]  i_char_code,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_value,
    input wire logic [1:0]  o_status
);

    logic in_xfer;
    logic in_digit;

    assign in_xfer  = i_valid && !o_stall;
    assign in_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_status))
        else $error("result changed while stalled");

    // Digits accumulate without occupying the sequencer
    a_digit_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && in_digit |=> !o_stall)
        else $error("digit transaction did not complete in one cycle");

    // Any other character occupies the sequencer
    a_other_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !in_digit |=> o_stall)
        else $error("non-digit transaction did not start the sequencer");

    // A result only appears out of a busy sequencer
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without an expression end");

endmodule

bind postfix_expression_evaluator pee_checker u_pee_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_char_code (i_char_code),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_value     (o_value),
    .o_status    (o_status)
);

`default_nettype wire

FILE: tb/postfix_expression_evaluator_test.sv
`default_nettype none

module postfix_expression_evaluator_test;
    import pee_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH    = 32;
    localparam int RANDOM_CHARS   = 1600;
    localparam int IDLE_LIMIT     = 4000;
    localparam int HOLD_CYCLES    = 600;
    localparam int HOLD_AFTER     = 30;
    localparam int DRAIN_CYCLES   = 100;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } t_outcome;

    typedef struct {
        string       text;
        bit          typed;
        logic [31:0] value;
        logic [1:0]  status;
    } t_case;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_char_code;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_value;
    logic [1:0]         o_status;

    postfix_expression_evaluator #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_char_code(i_char_code),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_value    (o_value),
        .o_status   (o_status)
    );

    // Evaluator state mirrored by the testbench
    logic [31:0] calc_stack [STACK_DEPTH];
    int          calc_depth  = 0;
    logic [31:0] calc_acc    = '0;
    bit          calc_in_num = 1'b0;
    logic [1:0]  calc_err    = ST_OK;

    t_outcome    expr_outcomes [$];
    logic [7:0]  expr_text [$];
    bit          typed_pending = 1'b0;
    t_outcome    typed_outcome;

    int failures      = 0;
    int chars_sent    = 0;
    int exprs_sent    = 0;
    int results_seen  = 0;
    int burst_left    = 0;
    int status_hits [4] = '{0, 0, 0, 0};

    logic [7:0] operators [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

    t_case cases [13] = '{
        '{"", 1'b1, 32'd0, ST_OK},
        '{"0", 1'b1, 32'd0, ST_OK},
        '{"2147483647", 1'b1, NUM_MAX, ST_OK},
        '{"9999999999", 1'b1, NUM_MAX, ST_OK},
        '{"12 34+5*6-7/_", 1'b0, 32'd0, ST_OK},
        '{"65536 65536*", 1'b1, 32'd0, ST_OK},
        '{"2147483647_1-1_/", 1'b1, 32'h8000_0000, ST_OK},
        '{"5 0/", 1'b1, 32'd0, ST_DIVZERO},
        '{"7*", 1'b1, 32'd0, ST_OPERAND},
        '{"_", 1'b1, 32'd0, ST_OPERAND},
        '{"1 0/+", 1'b1, 32'd0, ST_OPERAND},
        '{"1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 1 ",
          1'b1, 32'd1, ST_OVERFLOW},
        '{"a\377\001 4~3 8-", 1'b0, 32'd0, ST_OK}
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit is_digit(input logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    function automatic void push_operand(input logic [31:0] v);
        if (calc_depth < STACK_DEPTH) begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end else begin
            calc_err = ST_OVERFLOW;
        end
    endfunction

    function automatic logic [31:0] quot_trunc(input logic [31:0] num, input logic [31:0] den);
        logic [31:0] mag_n;
        logic [31:0] mag_d;
        logic [31:0] q;
        mag_n = num[31] ? 32'd0 - num : num;
        mag_d = den[31] ? 32'd0 - den : den;
        q = mag_n / mag_d;
        return (num[31] ^ den[31]) ? 32'd0 - q : q;
    endfunction

    function automatic void apply_operator(input logic [7:0] ch);
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] res;
        if (calc_depth == 0) begin
            calc_err = ST_OPERAND;
            return;
        end
        calc_depth--;
        rhs = calc_stack[calc_depth];
        // a lone operand is consumed and lost
        if (calc_depth == 0) begin
            calc_err = ST_OPERAND;
            return;
        end
        calc_depth--;
        lhs = calc_stack[calc_depth];
        case (ch)
            CH_PLUS:  res = lhs + rhs;
            CH_MINUS: res = lhs - rhs;
            CH_STAR:  res = lhs * rhs;
            default: begin
                if (rhs == 32'd0) begin
                    res = 32'd0;
                    calc_err = ST_DIVZERO;
                end else begin
                    res = quot_trunc(lhs, rhs);
                end
            end
        endcase
        push_operand(res);
    endfunction

    function automatic bit eval_char(input logic [7:0] ch, output t_outcome res);
        logic [63:0] wide;
        res = '0;
        if (is_digit(ch)) begin
            if (calc_in_num) begin
                wide = {32'd0, calc_acc} * 64'd10 + {56'd0, ch - CH_ZERO};
                calc_acc = (wide > {32'd0, NUM_MAX}) ? NUM_MAX : wide[31:0];
            end else begin
                calc_acc = {24'd0, ch - CH_ZERO};
                calc_in_num = 1'b1;
            end
            return 1'b0;
        end
        if (calc_in_num) begin
            push_operand(calc_acc);
            calc_in_num = 1'b0;
            calc_acc = '0;
        end
        case (ch)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: apply_operator(ch);
            CH_NEG: begin
                if (calc_depth == 0)
                    calc_err = ST_OPERAND;
                else
                    calc_stack[calc_depth-1] = 32'd0 - calc_stack[calc_depth-1];
            end
            CH_END: begin
                res.value  = (calc_depth != 0) ? calc_stack[calc_depth-1] : 32'd0;
                res.status = calc_err;
                calc_depth = 0;
                calc_acc = '0;
                calc_in_num = 1'b0;
                calc_err = ST_OK;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_char(input logic [7:0] ch);
        int gap;
        t_outcome res;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
            gap = 0;
        end
        burst_left--;
        repeat (gap) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= ch;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        chars_sent++;
        if (eval_char(ch, res)) begin
            if (typed_pending) begin
                res = typed_outcome;
                typed_pending = 1'b0;
            end
            expr_outcomes.push_back(res);
        end
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] filler_char();
        logic [7:0] ch;
        do begin
            ch = $urandom_range(1, 255);
        end while (is_digit(ch) || ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR ||
                   ch == CH_SLASH || ch == CH_NEG);
        return ch;
    endfunction

    function automatic void add_number();
        string       digits;
        logic [31:0] word;
        int          i;
        if (expr_text.size() != 0 && is_digit(expr_text[$]))
            expr_text.push_back(($urandom_range(0, 3) != 0) ? CH_SPACE : filler_char());
        case ($urandom_range(0, 9))
            0, 1:    digits = "0";
            2, 3, 4: digits = $sformatf("%0d", $urandom_range(1, 9));
            5, 6:    digits = $sformatf("%0d", $urandom_range(10, 99999));
            7: begin
                word = $urandom;
                digits = $sformatf("%0d", word);
            end
            8: begin
                // long run that saturates
                digits = "";
                repeat ($urandom_range(11, 14)) digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       digits = "1_";
                    1:       digits = "2147483647_1-";
                    2:       digits = "007";
                    default: digits = "2147483647";
                endcase
            end
        endcase
        for (i = 0; i < digits.len(); i++) expr_text.push_back(digits[i]);
    endfunction

    function automatic void build_expr();
        int kind;
        int depth;
        kind = $urandom_range(0, 19);
        depth = 0;
        expr_text.delete();
        if (kind < 2) begin
            repeat ($urandom_range(1, 12)) expr_text.push_back($urandom_range(1, 255));
        end else if (kind < 4) begin
            // run the stack up to and past its depth
            repeat ($urandom_range(28, 36)) add_number();
            repeat ($urandom_range(0, 4)) expr_text.push_back(operators[$urandom_range(0, 3)]);
        end else begin
            repeat ($urandom_range(1, 16)) begin
                if (depth < 2 || $urandom_range(0, 2) == 0) begin
                    add_number();
                    depth++;
                end else begin
                    expr_text.push_back(operators[$urandom_range(0, 3)]);
                    depth--;
                end
                if (depth > 0 && $urandom_range(0, 5) == 0) expr_text.push_back(CH_NEG);
            end
            if (kind < 7) begin
                repeat ($urandom_range(1, 3)) expr_text.push_back(operators[$urandom_range(0, 3)]);
            end else begin
                while (depth > 1) begin
                    expr_text.push_back(operators[$urandom_range(0, 3)]);
                    depth--;
                end
            end
            if ($urandom_range(0, 3) == 0) expr_text.push_back(CH_SPACE);
        end
    endfunction

    // Receiver stall pattern, with one long hold-off to back up the block
    initial begin
        int  mode;
        int  mode_left;
        bit  held;
        mode = 0;
        mode_left = 0;
        held = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 200);
                end
                mode_left--;
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expr_outcomes.size() == 0) begin
                $error("unexpected result: value %0d status %0d", o_value, o_status);
                failures++;
            end else begin
                want = expr_outcomes.pop_front();
                if (o_value !== want.value) begin
                    $error("value: expected %0d, got %0d", $signed(want.value), o_value);
                    failures++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    failures++;
                end
                results_seen++;
                status_hits[want.status]++;
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    initial begin
        int idle;
        idle = 0;
        wait (i_rst_n === 1'b1);
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("postfix_expression_evaluator regression: fail");
        $finish;
    end

    initial begin
        int row;
        int k;
        i_valid = 1'b0;
        i_char_code = CH_END;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < $size(cases); row++) begin
            for (k = 0; k < cases[row].text.len(); k++) send_char(cases[row].text[k]);
            typed_pending = cases[row].typed;
            typed_outcome = '{value: cases[row].value, status: cases[row].status};
            send_char(CH_END);
            exprs_sent++;
        end

        while (chars_sent < RANDOM_CHARS) begin
            build_expr();
            foreach (expr_text[k]) send_char(expr_text[k]);
            send_char(CH_END);
            exprs_sent++;
        end
        i_valid <= 1'b0;

        while (expr_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expr_outcomes.size() != 0) begin
            $error("%0d results never arrived", expr_outcomes.size());
            failures++;
        end

        $display("covered %0d characters in %0d expressions, %0d results checked",
                 chars_sent, exprs_sent, results_seen);
        $display("status mix: ok %0d, div by zero %0d, missing operand %0d, overflow %0d",
                 status_hits[ST_OK], status_hits[ST_DIVZERO], status_hits[ST_OPERAND],
                 status_hits[ST_OVERFLOW]);
        if (failures == 0)
            $display("postfix_expression_evaluator regression: pass");
        else
            $display("postfix_expression_evaluator regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
design/pee_pkg.sv
design/pee_alu.sv
design/postfix_expression_evaluator.sv
design/pee_checker.sv
tb/postfix_expression_evaluator_test.sv
